>>> sv/huffman_tree_walk_decoder_top_assert.svh
// Assertion macros used by the checker of the decoder.
`ifndef HUFFMAN_TREE_WALK_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define HTWD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("decoder port check failed");

// Next-cycle implication, off while reset is asserted.
`define HTWD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("decoder port check failed");

`endif

>>> sv/hfd_pkg.sv
`default_nettype none

package hfd_pkg;

	// Default sizes of the node table and the slot stack
	localparam int MAX_NODES_DEF   = 511;
	localparam int STACK_DEPTH_DEF = 256;

	// Field widths
	localparam int SYM_W     = 8;
	localparam int BYTE_BITS = 8;
	localparam int NB_W      = 4;
	localparam int TOP_BIT   = 7;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_NODE = 1'b0,
		OP_CODE = 1'b1
	} op_t;

	// Classified item as it sits in the queue
	typedef struct packed {
		op_t              op;
		logic             first_node;
		logic [SYM_W-1:0] node_symbol;
		logic             has_left;
		logic             has_right;
		logic [BYTE_BITS-1:0] code_byte;
		logic [NB_W-1:0]  nbits;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ALLOC,
		BK_LINK,
		BK_LOAD,
		BK_WALK,
		BK_FLUSH
	} bk_state_t;

endpackage

`default_nettype wire

>>> sv/hfd_if.sv
`default_nettype none

// Input channel: node records and code bytes
interface hfd_in_if import hfd_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic                 first_node;
	logic [SYM_W-1:0]     node_symbol_in;
	logic                 has_left;
	logic                 has_right;
	logic [BYTE_BITS-1:0] code_byte;
	logic [NB_W-1:0]      valid_bits;

	modport source (
		output valid, kind, first_node, node_symbol_in, has_left, has_right,
			code_byte, valid_bits,
		input  ready
	);
	modport sink (
		input  valid, kind, first_node, node_symbol_in, has_left, has_right,
			code_byte, valid_bits,
		output ready
	);
endinterface

// Output channel: decoded symbols and faults
interface hfd_out_if import hfd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol_out;
	logic             fault;
	logic             last;

	modport source (output valid, symbol_out, fault, last, input ready);
	modport sink (input valid, symbol_out, fault, last, output ready);
endinterface

`default_nettype wire

>>> sv/hfd_ram.sv
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port
module hfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/hfd_front.sv
`default_nettype none

// Front: takes input transfers, classifies them and queues them for the back
module hfd_front import hfd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	hfd_in_if.sink    item,
	output item_t     head,
	output logic      head_valid,
	input  wire logic head_pop
);

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	item_t          q_mem_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	item_t          cls;
	logic           push;
	logic           pop;

	// classify: kind to opcode, bit count clamped to one byte
	always_comb begin
		cls.op          = op_t'(item.kind);
		cls.first_node  = item.first_node;
		cls.node_symbol = item.node_symbol_in;
		cls.has_left    = item.has_left;
		cls.has_right   = item.has_right;
		cls.code_byte   = item.code_byte;
		if (item.valid_bits > NB_W'(BYTE_BITS)) begin
			cls.nbits = NB_W'(BYTE_BITS);
		end else begin
			cls.nbits = item.valid_bits;
		end
	end

	assign item.ready = (count_q != QCW'(QUEUE_DEPTH));
	assign push       = item.valid && item.ready;
	assign head_valid = (count_q != '0);
	assign pop        = head_pop && head_valid;
	assign head       = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/hfd_back.sv
`default_nettype none

// Back: builds the node table from node records and walks it for code bytes
module hfd_back import hfd_pkg::*; #(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire item_t  head,
	input  wire logic   head_valid,
	output logic        head_pop,
	hfd_out_if.source   result
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int UW  = $clog2(MAX_NODES + 1);
	localparam int SW  = NW + 1;
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int TW  = $clog2(STACK_DEPTH + 1);
	localparam int TW1 = TW + 1;

	bk_state_t        state_q, state_d;
	logic [UW-1:0]    nodes_used_q, nodes_used_d;
	logic [TW-1:0]    stack_top_q, stack_top_d;
	logic [NW-1:0]    walk_q, walk_d;
	logic [NW-1:0]    root_l_q, root_l_d, root_r_q, root_r_d;
	logic [NW-1:0]    idx_q, idx_d;
	logic [SYM_W-1:0] sym_q, sym_d;
	logic             hl_q, hl_d, hr_q, hr_d, pop_q, pop_d;
	logic [BYTE_BITS-1:0] code_q, code_d;
	logic [NB_W-1:0]  nbits_q, nbits_d, bit_q, bit_d;
	logic             pend_q, pend_d;
	logic [NW-1:0]    pend_node_q, pend_node_d;
	logic [NW-1:0]    cur_l_q, cur_l_d, cur_r_q, cur_r_d;
	logic             res_v_q, res_v_d;
	logic [SYM_W-1:0] res_sym_q, res_sym_d;
	logic             res_fault_q, res_fault_d;
	logic             out_v_q, out_v_d;
	logic [SYM_W-1:0] out_sym_q, out_sym_d;
	logic             out_fault_q, out_fault_d, out_last_q, out_last_d;

	// memory ports
	logic [SYM_W-1:0] rd_sym;
	logic [NW-1:0]    rd_l, rd_r;
	logic [SW-1:0]    slot_rd;
	logic             node_re;
	logic [NW-1:0]    node_raddr;
	logic             sym_we, left_we, right_we;
	logic [NW-1:0]    left_waddr, left_wdata, right_waddr, right_wdata;
	logic             slot_we, slot_re;
	logic [AW-1:0]    slot_waddr, slot_raddr;
	logic [SW-1:0]    slot_wdata;

	logic             out_free;
	logic             slot_ok;

	assign out_free = !out_v_q || result.ready;
	assign slot_ok  = !res_v_q || out_free;

	hfd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_NODES)) u_sym_ram (
		.clk(clk), .we(sym_we), .waddr(idx_q), .wdata(sym_q),
		.re(node_re), .raddr(node_raddr), .rdata(rd_sym)
	);

	hfd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_left_ram (
		.clk(clk), .we(left_we), .waddr(left_waddr), .wdata(left_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(rd_l)
	);

	hfd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_right_ram (
		.clk(clk), .we(right_we), .waddr(right_waddr), .wdata(right_wdata),
		.re(node_re), .raddr(node_raddr), .rdata(rd_r)
	);

	hfd_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(slot_re), .raddr(slot_raddr), .rdata(slot_rd)
	);

	// sequencer: next state, memory strobes and result handling
	always_comb begin
		logic [UW-1:0]        nu_eff;
		logic [TW-1:0]        top_eff;
		logic                 pops;
		logic [TW1-1:0]       new_top;
		logic [NW-1:0]        eff_l;
		logic [NW-1:0]        eff_r;
		logic [NW-1:0]        nxt;
		logic [NW-1:0]        parent;
		logic [BYTE_BITS-1:0] code_sh;
		logic                 emitted;
		logic                 can_step;
		logic                 missing;
		logic                 res_push;
		logic [SYM_W-1:0]     res_new_sym;
		logic                 res_new_fault;

		state_d      = state_q;
		nodes_used_d = nodes_used_q;
		stack_top_d  = stack_top_q;
		walk_d       = walk_q;
		root_l_d     = root_l_q;
		root_r_d     = root_r_q;
		idx_d        = idx_q;
		sym_d        = sym_q;
		hl_d         = hl_q;
		hr_d         = hr_q;
		pop_d        = pop_q;
		code_d       = code_q;
		nbits_d      = nbits_q;
		bit_d        = bit_q;
		pend_d       = pend_q;
		pend_node_d  = pend_node_q;
		cur_l_d      = cur_l_q;
		cur_r_d      = cur_r_q;
		res_v_d      = res_v_q;
		res_sym_d    = res_sym_q;
		res_fault_d  = res_fault_q;
		out_v_d      = out_v_q;
		out_sym_d    = out_sym_q;
		out_fault_d  = out_fault_q;
		out_last_d   = out_last_q;

		head_pop    = 1'b0;
		node_re     = 1'b0;
		node_raddr  = walk_q;
		sym_we      = 1'b0;
		left_we     = 1'b0;
		right_we    = 1'b0;
		left_waddr  = idx_q;
		left_wdata  = '0;
		right_waddr = idx_q;
		right_wdata = '0;
		slot_we     = 1'b0;
		slot_waddr  = stack_top_q[AW-1:0];
		slot_wdata  = {idx_q, 1'b0};
		slot_re     = 1'b0;
		slot_raddr  = '0;

		nu_eff        = nodes_used_q;
		top_eff       = stack_top_q;
		pops          = 1'b0;
		new_top       = '0;
		eff_l         = cur_l_q;
		eff_r         = cur_r_q;
		nxt           = '0;
		parent        = slot_rd[SW-1:1];
		code_sh       = code_q << bit_q[2:0];
		emitted       = 1'b0;
		can_step      = 1'b1;
		missing       = 1'b0;
		res_push      = 1'b0;
		res_new_sym   = '0;
		res_new_fault = 1'b0;

		// output register drains on a transfer
		if (result.ready) begin
			out_v_d = 1'b0;
		end

		unique case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					head_pop = 1'b1;
					if (head.op == OP_CODE) begin
						// no tree or a lone root: nothing to decode
						if (nodes_used_q != '0 && (root_l_q != '0 || root_r_q != '0)) begin
							code_d     = head.code_byte;
							nbits_d    = head.nbits;
							bit_d      = '0;
							pend_d     = 1'b0;
							node_re    = 1'b1;
							node_raddr = walk_q;
							state_d    = BK_LOAD;
						end
					end else begin
						if (head.first_node) begin
							nu_eff  = '0;
							top_eff = '0;
							walk_d  = '0;
						end
						nodes_used_d = nu_eff;
						stack_top_d  = top_eff;
						pops         = (nu_eff != '0);
						new_top      = TW1'(top_eff) - TW1'(pops) + TW1'(head.has_left)
							+ TW1'(head.has_right);
						if (pops && top_eff == '0) begin
							// tree complete: record dropped silently
						end else if (nu_eff >= UW'(MAX_NODES)
							|| new_top > TW1'(STACK_DEPTH)) begin
							// table or stack overflow: one fault result
							walk_d        = '0;
							res_push      = 1'b1;
							res_new_fault = 1'b1;
							state_d       = BK_FLUSH;
						end else begin
							idx_d        = nu_eff[NW-1:0];
							nodes_used_d = nu_eff + 1'b1;
							sym_d        = head.node_symbol;
							hl_d         = head.has_left;
							hr_d         = head.has_right;
							pop_d        = pops;
							if (pops) begin
								stack_top_d = top_eff - 1'b1;
								slot_re     = 1'b1;
								slot_raddr  = stack_top_d[AW-1:0];
							end
							state_d = BK_ALLOC;
						end
					end
				end
			end

			BK_ALLOC: begin
				// new node gets its symbol and empty links; right slot pushed first
				sym_we      = 1'b1;
				left_we     = 1'b1;
				right_we    = 1'b1;
				left_waddr  = idx_q;
				right_waddr = idx_q;
				if (idx_q == '0) begin
					root_l_d = '0;
					root_r_d = '0;
				end
				if (hr_q) begin
					slot_we     = 1'b1;
					slot_wdata  = {idx_q, 1'b1};
					stack_top_d = stack_top_q + 1'b1;
				end
				state_d = BK_LINK;
			end

			BK_LINK: begin
				// hook the node under the popped slot, then push the left slot
				if (pop_q) begin
					if (slot_rd[0]) begin
						right_we    = 1'b1;
						right_waddr = parent;
						right_wdata = idx_q;
						if (parent == '0) begin
							root_r_d = idx_q;
						end
					end else begin
						left_we    = 1'b1;
						left_waddr = parent;
						left_wdata = idx_q;
						if (parent == '0) begin
							root_l_d = idx_q;
						end
					end
				end
				if (hl_q) begin
					slot_we     = 1'b1;
					slot_wdata  = {idx_q, 1'b0};
					stack_top_d = stack_top_q + 1'b1;
				end
				state_d = BK_IDLE;
			end

			BK_LOAD: begin
				// links of the node where the walk stands
				cur_l_d = rd_l;
				cur_r_d = rd_r;
				state_d = BK_WALK;
			end

			BK_WALK: begin
				// settle the node whose read is pending
				if (pend_q) begin
					if (rd_l == '0 && rd_r == '0) begin
						if (slot_ok) begin
							res_push    = 1'b1;
							res_new_sym = rd_sym;
							emitted     = 1'b1;
							walk_d      = '0;
							eff_l       = root_l_q;
							eff_r       = root_r_q;
							cur_l_d     = root_l_q;
							cur_r_d     = root_r_q;
							pend_d      = 1'b0;
						end else begin
							can_step = 1'b0;
						end
					end else begin
						walk_d  = pend_node_q;
						eff_l   = rd_l;
						eff_r   = rd_r;
						cur_l_d = rd_l;
						cur_r_d = rd_r;
						pend_d  = 1'b0;
					end
				end else if (bit_q >= nbits_q) begin
					can_step = 1'b0;
					state_d  = BK_FLUSH;
				end

				// take the next code bit
				if (can_step && bit_q < nbits_q) begin
					nxt     = code_sh[TOP_BIT] ? eff_r : eff_l;
					missing = (nxt == '0) || (UW'(nxt) >= nodes_used_q);
					if (!missing) begin
						node_re     = 1'b1;
						node_raddr  = nxt;
						pend_d      = 1'b1;
						pend_node_d = nxt;
						bit_d       = bit_q + 1'b1;
					end else if (!emitted && slot_ok) begin
						res_push      = 1'b1;
						res_new_fault = 1'b1;
						walk_d        = '0;
						cur_l_d       = root_l_q;
						cur_r_d       = root_r_q;
						pend_d        = 1'b0;
						bit_d         = bit_q + 1'b1;
					end
				end
			end

			BK_FLUSH: begin
				// final result of the item goes out marked last
				if (!res_v_q) begin
					state_d = BK_IDLE;
				end else if (out_free) begin
					out_v_d     = 1'b1;
					out_sym_d   = res_sym_q;
					out_fault_d = res_fault_q;
					out_last_d  = 1'b1;
					res_v_d     = 1'b0;
					state_d     = BK_IDLE;
				end
			end

			default: begin
				state_d = BK_IDLE;
			end
		endcase

		// a new result displaces the held one, which was not the last
		if (res_push) begin
			if (res_v_q) begin
				out_v_d     = 1'b1;
				out_sym_d   = res_sym_q;
				out_fault_d = res_fault_q;
				out_last_d  = 1'b0;
			end
			res_v_d     = 1'b1;
			res_sym_d   = res_new_sym;
			res_fault_d = res_new_fault;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			nodes_used_q <= '0;
			stack_top_q  <= '0;
			walk_q       <= '0;
			bit_q        <= '0;
			pend_q       <= 1'b0;
			res_v_q      <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			state_q      <= state_d;
			nodes_used_q <= nodes_used_d;
			stack_top_q  <= stack_top_d;
			walk_q       <= walk_d;
			bit_q        <= bit_d;
			pend_q       <= pend_d;
			res_v_q      <= res_v_d;
			out_v_q      <= out_v_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		root_l_q    <= root_l_d;
		root_r_q    <= root_r_d;
		idx_q       <= idx_d;
		sym_q       <= sym_d;
		hl_q        <= hl_d;
		hr_q        <= hr_d;
		pop_q       <= pop_d;
		code_q      <= code_d;
		nbits_q     <= nbits_d;
		pend_node_q <= pend_node_d;
		cur_l_q     <= cur_l_d;
		cur_r_q     <= cur_r_d;
		res_sym_q   <= res_sym_d;
		res_fault_q <= res_fault_d;
		out_sym_q   <= out_sym_d;
		out_fault_q <= out_fault_d;
		out_last_q  <= out_last_d;
	end

	assign result.valid      = out_v_q;
	assign result.symbol_out = out_sym_q;
	assign result.fault      = out_fault_q;
	assign result.last       = out_last_q;

endmodule

`default_nettype wire

>>> sv/huffman_tree_walk_decoder_top.sv
// Huffman tree-walk decoder.
// item channel: valid/ready; kind 0 carries a preorder node record (symbol,
// has_left, has_right, first_node), kind 1 a code byte with valid_bits used
// bits, MSB first. result channel: valid/ready; symbol_out, fault, last.
// A transfer on item lands in a two-entry queue; the back end drains it.
// Node record: the back end pops a slot, writes the node and links it to its
// parent; a dropped record skips this and an overflow yields a fault result.
// Code byte: the back end loads the links of the node where the walk stands,
// then makes one node-table read per bit and flushes the held result; with
// no tree to walk the byte is dropped; each bit waits on the previous read.
// Each result is held one step so that last can be set on the final one; it
// reaches the output register when the next is found or the byte ends.
// Reset clears the queue, the walk (back at the root), the node and slot
// counts and the output register; the node table is not cleared and entries
// become valid as nodes are allocated. A stalled result channel freezes the
// walk once the output register and the hold register are both full; the
// item channel keeps taking transfers until the queue fills.
`default_nettype none

module huffman_tree_walk_decoder_top import hfd_pkg::*; #(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hfd_in_if.sink    item,
	hfd_out_if.source result
);

	item_t head;
	logic  head_valid;
	logic  head_pop;

	hfd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.head(head),
		.head_valid(head_valid),
		.head_pop(head_pop)
	);

	hfd_back #(
		.MAX_NODES(MAX_NODES),
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.head_pop(head_pop),
		.result(result)
	);

endmodule

`default_nettype wire

>>> sv/hfd_checker.sv
`default_nettype none
`include "huffman_tree_walk_decoder_top_assert.svh"

// Port-level checks of the decoder
module hfd_checker import hfd_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [SYM_W-1:0] symbol_out,
	input wire logic             fault,
	input wire logic             last
);

	// out of reset the queue can take a transfer and no result is pending
	`HTWD_ASSERT_IMP(a_reset_clean, clk, arst_n, !$past(arst_n), in_ready && !out_valid)

	// a fault result never carries a symbol
	`HTWD_ASSERT_IMP(a_fault_zero, clk, arst_n, out_valid && fault, symbol_out == '0)

	// a stalled result holds
	`HTWD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(symbol_out) && $stable(fault) && $stable(last))

	// the queue cannot fill without a transfer
	`HTWD_ASSERT_NXT(a_ready_hold, clk, arst_n, in_ready && !in_valid, in_ready)

endmodule

bind huffman_tree_walk_decoder_top hfd_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(item.valid),
	.in_ready(item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.symbol_out(result.symbol_out),
	.fault(result.fault),
	.last(result.last)
);

`default_nettype wire
